// ----- src/tfs_pkg.sv -----
package tfs_pkg;

    localparam logic [7:0] SYNC_BYTE    = 8'hC8;
    localparam logic [7:0] TYPE_BATTERY = 8'h08;
    localparam logic [7:0] TYPE_GPS     = 8'h02;
    localparam logic [7:0] CRC_POLY     = 8'hD5;

    localparam int unsigned BATT_SIZE = 12;
    localparam int unsigned GPS_SIZE  = 19;
    localparam int unsigned IDX_W     = $clog2(GPS_SIZE);

    localparam logic [7:0] BATT_LEN = 8'(BATT_SIZE - 2);
    localparam logic [7:0] GPS_LEN  = 8'(GPS_SIZE - 2);

    localparam logic KIND_BATTERY = 1'b0;
    localparam logic KIND_GPS     = 1'b1;

    // floor(2^32 / divisor)
    localparam logic [31:0] RECIP_25   = 32'd171798691;
    localparam logic [31:0] RECIP_1000 = 32'd4294967;

    localparam logic [15:0] ALT_OFFSET = 16'd1000;

    localparam int unsigned TFS_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic               kind;
        logic [15:0]        supply_voltage;
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic [23:0]        ground_speed;
        logic [25:0]        heading;
        logic signed [31:0] altitude;
        logic [7:0]         satellite_count;
    } tfs_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } tfs_out_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] decivolts;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [15:0] speed;
        logic [15:0] heading;
        logic [15:0] alt;
        logic [7:0]  sats;
    } tfs_desc_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- src/telemetry_frame_serializer.sv -----
// Telemetry frame serializer. Each input beat requests one frame; the block answers with the
// whole frame on the m_ side, one byte per beat, with last set on the closing CRC8 byte
// (polynomial 0xD5, init 0, over type byte through payload). A battery request (kind 0) gives
// 12 beats and a GPS request (kind 1) gives 19 beats, so the byte serializer sets the request rate;
// at full output speed frames run back to back with no gap. Requests pass a three-stage front
// pipeline that does the scaling (reciprocal multiply, remainder correction, saturation) and
// wait in a QUEUE_DEPTH-entry queue, so the input takes new requests while a frame is still
// being sent; the first byte passes the three front stages, the queue and the output register.
module telemetry_frame_serializer import tfs_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = TFS_QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tfs_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output tfs_out_t m_data
);

    logic      f_valid, f_ready;
    tfs_desc_t f_data;
    logic      q_valid, q_ready;
    tfs_desc_t q_data;

    tfs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .d_valid (f_valid),
        .d_ready (f_ready),
        .d_data  (f_data)
    );

    tfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    tfs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // a frame leaves the queue only as its CRC beat is loaded
    a_pop_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_ready |=> m_valid && m_data.last)
        else $error("queue pop without last beat");

    // a full queue always has a frame to send
    a_full_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        !f_ready |-> q_valid)
        else $error("queue full but empty head");

    // the beat after a frame end starts the next frame
    a_sync_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last |=> !m_valid || (m_data.out_byte == SYNC_BYTE))
        else $error("frame does not start with sync");

endmodule

// ----- src/tfs_front.sv -----
module tfs_front import tfs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  tfs_in_t   s_data,
    output logic      d_valid,
    input  logic      d_ready,
    output tfs_desc_t d_data
);

    // stage 1: reciprocal multiplies
    logic        s1_valid_reg;
    logic        s1_kind_reg;
    logic [15:0] s1_dv_reg;
    logic [31:0] s1_lat_reg, s1_lon_reg;
    logic [7:0]  s1_sats_reg;
    logic [27:0] s1_spd_x_reg;
    logic [23:0] s1_spd_q0_reg;
    logic [25:0] s1_hdg_reg;
    logic [16:0] s1_hdg_q0_reg;
    logic        s1_alt_neg_reg;
    logic [31:0] s1_alt_mag_reg;
    logic [21:0] s1_alt_q0_reg;

    // stage 2: remainder check
    logic        s2_valid_reg;
    logic        s2_kind_reg;
    logic [15:0] s2_dv_reg;
    logic [31:0] s2_lat_reg, s2_lon_reg;
    logic [7:0]  s2_sats_reg;
    logic [23:0] s2_spd_q0_reg;
    logic        s2_spd_inc_reg;
    logic [16:0] s2_hdg_q0_reg;
    logic        s2_hdg_inc_reg;
    logic        s2_alt_neg_reg;
    logic [21:0] s2_alt_q0_reg;
    logic        s2_alt_inc_reg;

    // stage 3: correction and saturation
    logic      s3_valid_reg;
    tfs_desc_t s3_desc_reg;

    logic s1_ready, s2_ready, s3_ready;

    assign s3_ready = !s3_valid_reg || d_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_ready  = s1_ready;

    // stage 1 combinational
    logic [19:0] dv_x10;
    logic [15:0] dv_next;
    logic [27:0] spd_x_next;
    logic [59:0] spd_prod;
    logic [57:0] hdg_prod;
    logic [31:0] alt_raw;
    logic        alt_neg_next;
    logic [31:0] alt_mag_next;
    logic [63:0] alt_prod;

    assign dv_x10       = {1'b0, s_data.supply_voltage, 3'b000}
                        + {3'b000, s_data.supply_voltage, 1'b0};
    assign dv_next      = {4'b0000, dv_x10[19:8]};
    assign spd_x_next   = {1'b0, s_data.ground_speed, 3'b000} + {4'b0000, s_data.ground_speed};
    assign spd_prod     = spd_x_next * RECIP_25;
    assign hdg_prod     = s_data.heading * RECIP_1000;
    assign alt_raw      = s_data.altitude;
    assign alt_neg_next = alt_raw[31];
    assign alt_mag_next = alt_neg_next ? (~alt_raw + 32'd1) : alt_raw;
    assign alt_prod     = alt_mag_next * RECIP_1000;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s_valid;
        end
        if (s1_ready && s_valid) begin
            s1_kind_reg    <= s_data.kind;
            s1_dv_reg      <= dv_next;
            s1_lat_reg     <= s_data.latitude;
            s1_lon_reg     <= s_data.longitude;
            s1_sats_reg    <= s_data.satellite_count;
            s1_spd_x_reg   <= spd_x_next;
            s1_spd_q0_reg  <= spd_prod[55:32];
            s1_hdg_reg     <= s_data.heading;
            s1_hdg_q0_reg  <= hdg_prod[48:32];
            s1_alt_neg_reg <= alt_neg_next;
            s1_alt_mag_reg <= alt_mag_next;
            s1_alt_q0_reg  <= alt_prod[53:32];
        end
    end

    // stage 2 combinational
    logic [27:0] spd_rem;
    logic [25:0] hdg_rem;
    logic [31:0] alt_rem;
    logic        spd_inc_next, hdg_inc_next, alt_inc_next;

    assign spd_rem      = s1_spd_x_reg - (28'(s1_spd_q0_reg) * 28'd25);
    assign hdg_rem      = s1_hdg_reg - (26'(s1_hdg_q0_reg) * 26'd1000);
    assign alt_rem      = s1_alt_mag_reg - (32'(s1_alt_q0_reg) * 32'd1000);
    assign spd_inc_next = spd_rem >= 28'd25;
    assign hdg_inc_next = hdg_rem >= 26'd1000;
    assign alt_inc_next = alt_rem >= 32'd1000;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_kind_reg    <= s1_kind_reg;
            s2_dv_reg      <= s1_dv_reg;
            s2_lat_reg     <= s1_lat_reg;
            s2_lon_reg     <= s1_lon_reg;
            s2_sats_reg    <= s1_sats_reg;
            s2_spd_q0_reg  <= s1_spd_q0_reg;
            s2_spd_inc_reg <= spd_inc_next;
            s2_hdg_q0_reg  <= s1_hdg_q0_reg;
            s2_hdg_inc_reg <= hdg_inc_next;
            s2_alt_neg_reg <= s1_alt_neg_reg;
            s2_alt_q0_reg  <= s1_alt_q0_reg;
            s2_alt_inc_reg <= alt_inc_next;
        end
    end

    // stage 3 combinational
    logic [23:0] spd_q;
    logic [16:0] hdg_q;
    logic [21:0] alt_q;
    logic [22:0] alt_sum;
    tfs_desc_t   desc_next;

    assign spd_q   = s2_spd_q0_reg + 24'(s2_spd_inc_reg);
    assign hdg_q   = s2_hdg_q0_reg + 17'(s2_hdg_inc_reg);
    assign alt_q   = s2_alt_q0_reg + 22'(s2_alt_inc_reg);
    assign alt_sum = {1'b0, alt_q} + 23'(ALT_OFFSET);

    always_comb begin
        desc_next.kind      = s2_kind_reg;
        desc_next.decivolts = s2_dv_reg;
        desc_next.lat       = s2_lat_reg;
        desc_next.lon       = s2_lon_reg;
        desc_next.sats      = s2_sats_reg;
        desc_next.speed     = (|spd_q[23:16]) ? 16'hFFFF : spd_q[15:0];
        desc_next.heading   = hdg_q[16] ? 16'hFFFF : hdg_q[15:0];
        if (s2_alt_neg_reg) begin
            desc_next.alt = (alt_q >= 22'(ALT_OFFSET)) ? 16'd0
                          : ALT_OFFSET - {6'b000000, alt_q[9:0]};
        end else begin
            desc_next.alt = (|alt_sum[22:16]) ? 16'hFFFF : alt_sum[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= s2_valid_reg;
        end
        if (s3_ready && s2_valid_reg) begin
            s3_desc_reg <= desc_next;
        end
    end

    assign d_valid = s3_valid_reg;
    assign d_data  = s3_desc_reg;

endmodule

// ----- src/tfs_queue.sv -----
module tfs_queue import tfs_pkg::*; #(
    parameter int unsigned DEPTH = TFS_QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  tfs_desc_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output tfs_desc_t out_data
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tfs_desc_t         entry [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push, pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = entry[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            entry[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ----- src/tfs_back.sv -----
module tfs_back import tfs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    output logic      q_ready,
    input  tfs_desc_t q_data,
    output logic      m_valid,
    input  logic      m_ready,
    output tfs_out_t  m_data
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       crc_reg, crc_next;
    logic             m_valid_reg, m_valid_next;
    tfs_out_t         m_data_reg, m_data_next;

    logic             adv;
    logic             is_last;
    logic [IDX_W-1:0] last_idx;
    logic [7:0]       cur_byte;

    assign adv      = q_valid && (!m_valid_reg || m_ready);
    assign last_idx = (q_data.kind == KIND_GPS) ? IDX_W'(GPS_SIZE - 1) : IDX_W'(BATT_SIZE - 1);
    assign is_last  = idx_reg == last_idx;
    assign q_ready  = adv && is_last;

    always_comb begin
        cur_byte = 8'h00;
        if (q_data.kind == KIND_GPS) begin
            unique case (idx_reg)
                5'd0:    cur_byte = SYNC_BYTE;
                5'd1:    cur_byte = GPS_LEN;
                5'd2:    cur_byte = TYPE_GPS;
                5'd3:    cur_byte = q_data.lat[31:24];
                5'd4:    cur_byte = q_data.lat[23:16];
                5'd5:    cur_byte = q_data.lat[15:8];
                5'd6:    cur_byte = q_data.lat[7:0];
                5'd7:    cur_byte = q_data.lon[31:24];
                5'd8:    cur_byte = q_data.lon[23:16];
                5'd9:    cur_byte = q_data.lon[15:8];
                5'd10:   cur_byte = q_data.lon[7:0];
                5'd11:   cur_byte = q_data.speed[15:8];
                5'd12:   cur_byte = q_data.speed[7:0];
                5'd13:   cur_byte = q_data.heading[15:8];
                5'd14:   cur_byte = q_data.heading[7:0];
                5'd15:   cur_byte = q_data.alt[15:8];
                5'd16:   cur_byte = q_data.alt[7:0];
                5'd17:   cur_byte = q_data.sats;
                default: cur_byte = 8'h00;
            endcase
        end else begin
            unique case (idx_reg)
                5'd0:    cur_byte = SYNC_BYTE;
                5'd1:    cur_byte = BATT_LEN;
                5'd2:    cur_byte = TYPE_BATTERY;
                5'd3:    cur_byte = q_data.decivolts[15:8];
                5'd4:    cur_byte = q_data.decivolts[7:0];
                default: cur_byte = 8'h00;
            endcase
        end
    end

    always_comb begin
        idx_next     = idx_reg;
        crc_next     = crc_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (adv) begin
            m_valid_next         = 1'b1;
            m_data_next.out_byte = is_last ? crc_reg : cur_byte;
            m_data_next.last     = is_last;
            idx_next             = is_last ? '0 : idx_reg + 1'b1;
            if (idx_reg < IDX_W'(2)) begin
                crc_next = 8'h00;
            end else if (!is_last) begin
                crc_next = crc8_update(crc_reg, cur_byte);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
        crc_reg    <= crc_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- tb/telemetry_frame_serializer_tb.sv -----
module telemetry_frame_serializer_tb;
    import tfs_pkg::*;

    localparam int unsigned SINK_HOLD_CYCLES = 400;
    localparam int unsigned MAX_REPORTS      = 10;
    localparam int unsigned DRAIN_LIMIT      = 20000;
    localparam int unsigned TAIL_CYCLES      = 20;

    typedef struct {
        tfs_in_t   req;
        bit        pinned;
        tfs_desc_t scaled;
    } stim_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    tfs_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    tfs_out_t m_data;

    tfs_out_t  pending_bytes[$];
    int        err_count  = 0;
    bit        src_gaps   = 1'b1;
    bit        sink_gaps  = 1'b1;
    bit        sink_hold  = 1'b0;
    stim_row_t dir_tab[$];

    telemetry_frame_serializer u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("telemetry_frame_serializer_tb: FAIL");
        $finish;
    end

    function automatic logic [15:0] clamp16(longint v);
        if (v <= 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    function automatic tfs_desc_t scale_request(tfs_in_t r);
        tfs_desc_t d;
        d = '0;
        d.kind      = r.kind;
        d.decivolts = 16'((32'(r.supply_voltage) * 32'd10) >> 8);
        d.lat       = r.latitude;
        d.lon       = r.longitude;
        d.speed     = clamp16((longint'(r.ground_speed) * 36) / 100);
        d.heading   = clamp16(longint'(r.heading) / 1000);
        // signed divide truncates toward zero
        d.alt       = clamp16(longint'(r.altitude) / 1000 + 1000);
        d.sats      = r.satellite_count;
        return d;
    endfunction

    function automatic logic [7:0] crc_fold(logic [7:0] crc, logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int b = 7; b >= 0; b--) begin
            fb = c[7] ^ data[b];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic void append_frame(tfs_desc_t d);
        logic [7:0]  fr[GPS_SIZE];
        int unsigned n;
        logic [7:0]  crc;
        tfs_out_t    beat;
        for (int i = 0; i < GPS_SIZE; i++) fr[i] = 8'h00;
        fr[0] = SYNC_BYTE;
        if (d.kind == KIND_BATTERY) begin
            n = BATT_SIZE;
            fr[1] = BATT_LEN;
            fr[2] = TYPE_BATTERY;
            fr[3] = d.decivolts[15:8];
            fr[4] = d.decivolts[7:0];
        end else begin
            n = GPS_SIZE;
            fr[1] = GPS_LEN;
            fr[2] = TYPE_GPS;
            {fr[3], fr[4], fr[5], fr[6]}     = d.lat;
            {fr[7], fr[8], fr[9], fr[10]}    = d.lon;
            {fr[11], fr[12]}                 = d.speed;
            {fr[13], fr[14]}                 = d.heading;
            {fr[15], fr[16]}                 = d.alt;
            fr[17] = d.sats;
        end
        crc = 8'h00;
        for (int i = 2; i < n - 1; i++) crc = crc_fold(crc, fr[i]);
        fr[n - 1] = crc;
        for (int i = 0; i < n; i++) begin
            beat.out_byte = fr[i];
            beat.last     = (i == n - 1);
            pending_bytes.push_back(beat);
        end
    endfunction

    // pinned rows carry hand-computed scaled fields; raw fields are copied
    function automatic stim_row_t make_row(logic kind, logic [15:0] volt, logic [31:0] lat,
                                           logic [31:0] lon, logic [23:0] spd,
                                           logic [25:0] hdg, logic [31:0] alt,
                                           logic [7:0] sats, bit pinned,
                                           logic [15:0] exp_a, logic [15:0] exp_b,
                                           logic [15:0] exp_c);
        stim_row_t row;
        row.req.kind            = kind;
        row.req.supply_voltage  = volt;
        row.req.latitude        = lat;
        row.req.longitude       = lon;
        row.req.ground_speed    = spd;
        row.req.heading         = hdg;
        row.req.altitude        = alt;
        row.req.satellite_count = sats;
        row.pinned              = pinned;
        row.scaled              = '0;
        row.scaled.kind         = kind;
        if (kind == KIND_BATTERY) begin
            row.scaled.decivolts = exp_a;
        end else begin
            row.scaled.lat     = lat;
            row.scaled.lon     = lon;
            row.scaled.speed   = exp_a;
            row.scaled.heading = exp_b;
            row.scaled.alt     = exp_c;
            row.scaled.sats    = sats;
        end
        return row;
    endfunction

    function automatic tfs_in_t rand_request();
        tfs_in_t r;
        int      sel;
        r.kind            = 1'($urandom_range(0, 1));
        r.supply_voltage  = 16'($urandom);
        r.latitude        = $urandom;
        r.longitude       = $urandom;
        r.satellite_count = 8'($urandom);
        sel = $urandom_range(0, 3);
        case (sel)
            0: r.ground_speed = 24'($urandom_range(0, 200000));
            1: r.ground_speed = 24'($urandom_range(181990, 182100));
            default: r.ground_speed = 24'($urandom);
        endcase
        sel = $urandom_range(0, 3);
        if (sel == 0) r.heading = 26'($urandom);
        else r.heading = 26'($urandom_range(0, 36000000));
        sel = $urandom_range(0, 4);
        case (sel)
            0: r.altitude = int'($urandom_range(0, 3000000)) - 1500000;
            1: r.altitude = int'($urandom_range(0, 70000000));
            2: r.altitude = int'($urandom_range(0, 4000)) + 64533000;
            3: r.altitude = -int'($urandom_range(998000, 1003000));
            default: r.altitude = $urandom;
        endcase
        return r;
    endfunction

    task automatic send_request(tfs_in_t req, bit pinned, tfs_desc_t scaled);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        append_frame(pinned ? scaled : scale_request(req));
    endtask

    task automatic send_random();
        send_request(rand_request(), 1'b0, '0);
    endtask

    task automatic drain_frames();
        s_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
    endtask

    task automatic note_error(string what, tfs_out_t want, tfs_out_t got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
                     $time, what, want.out_byte, want.last, got.out_byte, got.last);
    endtask

    always @(posedge aclk) begin
        tfs_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_bytes.size() == 0) begin
                note_error("unexpected beat", '0, m_data);
            end else begin
                want = pending_bytes.pop_front();
                if (m_data.out_byte !== want.out_byte || m_data.last !== want.last)
                    note_error("beat mismatch", want, m_data);
            end
        end
    end

    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold) begin
                m_ready <= 1'b0;
                for (int c = 0; c < SINK_HOLD_CYCLES; c++) @(posedge aclk);
                sink_hold = 1'b0;
            end else if (sink_gaps && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    initial begin
        int unsigned waited;

        dir_tab.push_back(make_row(KIND_BATTERY, 16'd0, '1, '1, '1, '1, '1, '1,
                                   1'b1, 16'd0, 16'd0, 16'd0));
        dir_tab.push_back(make_row(KIND_BATTERY, 16'hFFFF, '0, '0, '0, '0, '0, '0,
                                   1'b1, 16'd2559, 16'd0, 16'd0));
        dir_tab.push_back(make_row(KIND_BATTERY, 16'd256, 32'h1234_5678, 32'h9ABC_DEF0,
                                   24'hA5A5A5, 26'h2AAAAAA, 32'h8000_0000, 8'h5A,
                                   1'b1, 16'd10, 16'd0, 16'd0));
        dir_tab.push_back(make_row(KIND_BATTERY, 16'h5A5A, '0, '1, '0, '1, '0, '1,
                                   1'b0, 16'd0, 16'd0, 16'd0));
        dir_tab.push_back(make_row(KIND_GPS, 16'hFFFF, 32'd0, 32'd0, 24'd0, 26'd0, 32'd0, 8'd0,
                                   1'b1, 16'd0, 16'd0, 16'd1000));
        dir_tab.push_back(make_row(KIND_GPS, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                   24'hFFFFFF, 26'd36000000, 32'h7FFF_FFFF, 8'hFF,
                                   1'b1, 16'd65535, 16'd36000, 16'd65535));
        dir_tab.push_back(make_row(KIND_GPS, 16'h1234, 32'h8000_0000, 32'h7FFF_FFFF,
                                   24'd182044, 26'd65535999, 32'h8000_0000, 8'h55,
                                   1'b1, 16'd65535, 16'd65535, 16'd0));
        dir_tab.push_back(make_row(KIND_GPS, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   24'd182045, 26'd65536000, -32'sd1000000, 8'hAA,
                                   1'b1, 16'd65535, 16'd65535, 16'd0));
        dir_tab.push_back(make_row(KIND_GPS, 16'h0, 32'h0102_0304, 32'hF1F2_F3F4,
                                   24'd1000, 26'h3FFFFFF, -32'sd999, 8'd12,
                                   1'b1, 16'd360, 16'd65535, 16'd1000));
        dir_tab.push_back(make_row(KIND_GPS, 16'h0, 32'h2A5B_C3D1, 32'hD5A4_3C2E,
                                   24'd2, 26'd999, -32'sd1001, 8'd7,
                                   1'b1, 16'd0, 16'd0, 16'd999));
        dir_tab.push_back(make_row(KIND_GPS, 16'h0, 32'h5555_5555, 32'hAAAA_AAAA,
                                   24'd3, 26'd1000, -32'sd999999, 8'd1,
                                   1'b1, 16'd1, 16'd1, 16'd1));
        dir_tab.push_back(make_row(KIND_GPS, 16'h0, 32'hAAAA_AAAA, 32'h5555_5555,
                                   24'd100, 26'd123456, 32'sd64535999, 8'd9,
                                   1'b1, 16'd36, 16'd123, 16'd65535));
        dir_tab.push_back(make_row(KIND_GPS, 16'h0, 32'h0000_0001, 32'h8000_0001,
                                   24'd182043, 26'd35999999, 32'sd64536000, 8'd30,
                                   1'b1, 16'd65535, 16'd35999, 16'd65535));
        dir_tab.push_back(make_row(KIND_GPS, 16'h0, 32'h1C9C_3800, 32'hF5E1_0000,
                                   24'd5000, 26'd18000000, -32'sd1000999, 8'd14,
                                   1'b1, 16'd1800, 16'd18000, 16'd0));
        dir_tab.push_back(make_row(KIND_GPS, 16'hBEEF, 32'hDEAD_BEEF, 32'hCAFE_F00D,
                                   24'h00BEEF, 26'h00ABCDE, -32'sd1001000, 8'h3C,
                                   1'b0, 16'd0, 16'd0, 16'd0));
        dir_tab.push_back(make_row(KIND_GPS, 16'h0, 32'h0BAD_CAFE, 32'h7654_3210,
                                   24'd1234567, 26'd27000000, 32'sd152400, 8'd21,
                                   1'b0, 16'd0, 16'd0, 16'd0));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) send_request(dir_tab[i].req, dir_tab[i].pinned, dir_tab[i].scaled);
        drain_frames();

        repeat (60) send_random();
        drain_frames();

        // sink stalls long while the source keeps offering back to back
        src_gaps  = 1'b0;
        sink_hold = 1'b1;
        repeat (12) send_random();

        src_gaps = 1'b1;
        repeat (50) send_random();

        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        repeat (30) send_random();
        s_valid <= 1'b0;

        waited = 0;
        while (pending_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_bytes.size() != 0) begin
            err_count++;
            $display("%0d expected beats never arrived", pending_bytes.size());
        end

        if (err_count == 0) begin
            $display("telemetry_frame_serializer_tb: PASS");
        end else begin
            $display("telemetry_frame_serializer_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- telemetry_frame_serializer.f -----
src/tfs_pkg.sv
src/tfs_front.sv
src/tfs_queue.sv
src/tfs_back.sv
src/telemetry_frame_serializer.sv
tb/telemetry_frame_serializer_tb.sv
